/* sv/tga_pkg.sv */
// ----------------------------------------------------------------------------
// tga_pkg
// Shared types and constants for the TGA image stream decoder.
// ----------------------------------------------------------------------------
package tga_pkg;

    // Default depth of the queue between the front and back parts
    localparam int QUEUE_DEPTH = 4;

    // Header byte positions
    localparam logic [4:0] HDR_TYPE_LO   = 5'd2;
    localparam logic [4:0] HDR_TYPE_HI   = 5'd3;
    localparam logic [4:0] HDR_WIDTH_LO  = 5'd12;
    localparam logic [4:0] HDR_WIDTH_HI  = 5'd13;
    localparam logic [4:0] HDR_HEIGHT_LO = 5'd14;
    localparam logic [4:0] HDR_HEIGHT_HI = 5'd15;
    localparam logic [4:0] HDR_DEPTH     = 5'd16;
    localparam logic [4:0] HDR_LAST      = 5'd17;

    // Image types carrying uncompressed pixels, and the RLE flag bit
    localparam logic [15:0] TYPE_RAW_COLOUR = 16'd2;
    localparam logic [15:0] TYPE_RAW_GREY   = 16'd3;
    localparam int          TYPE_RLE_BIT    = 3;

    // Largest supported bytes per pixel
    localparam logic [4:0] MAX_BPP = 5'd4;

    // Result kinds
    localparam logic [1:0] KIND_HEADER    = 2'd0;
    localparam logic [1:0] KIND_RUN       = 2'd1;
    localparam logic [1:0] KIND_BAD_DEPTH = 2'd2;

    // Body parsing phase (the header is tracked by the front part)
    typedef enum logic [1:0] {
        PH_RAW_PIXEL,
        PH_PACKET_HEAD,
        PH_PACKET_PIXEL,
        PH_DONE
    } tga_phase_t;

    // Input beat
    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_of_file;
    } tga_in_t;

    // Result beat
    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] pixel_value;
        logic [7:0]  repeat_count;
        logic [15:0] image_width;
        logic [15:0] image_height;
        logic [7:0]  bit_depth;
        logic        last;
    } tga_out_t;

    // Classified byte passed from front to back
    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_header;
        logic [4:0] hdr_pos;
    } tga_item_t;

endpackage

/* sv/tga_front.sv */
// ----------------------------------------------------------------------------
// tga_front
// Accepts file bytes and tags each as a header byte (with its position)
// or a body byte, then pushes it into the queue.
// ----------------------------------------------------------------------------
module tga_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               byte_valid,
    output logic               byte_ready,
    input  tga_pkg::tga_in_t   byte_data,
    input  logic               queue_full,
    output logic               push,
    output tga_pkg::tga_item_t push_item
);

    logic [4:0] hdr_pos_reg, hdr_pos_next;
    logic       in_header_reg, in_header_next;
    logic [4:0] pos;
    logic       hdr;

    // A start flag restarts the header at position zero
    assign pos        = byte_data.start_of_file ? 5'd0 : hdr_pos_reg;
    assign hdr        = byte_data.start_of_file | in_header_reg;
    assign byte_ready = !queue_full;
    assign push       = byte_valid && !queue_full;

    always_comb
    begin
        push_item.data_byte = byte_data.data_byte;
        push_item.is_header = hdr;
        push_item.hdr_pos   = pos;
    end

    // Header position tracking
    always_comb
    begin
        hdr_pos_next   = hdr_pos_reg;
        in_header_next = in_header_reg;
        if (push && hdr)
        begin
            if (pos == tga_pkg::HDR_LAST)
            begin
                hdr_pos_next   = 5'd0;
                in_header_next = 1'b0;
            end
            else
            begin
                hdr_pos_next   = pos + 5'd1;
                in_header_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_pos_reg   <= 5'd0;
            in_header_reg <= 1'b1;
        end
        else
        begin
            hdr_pos_reg   <= hdr_pos_next;
            in_header_reg <= in_header_next;
        end
    end

endmodule

/* sv/tga_queue.sv */
// ----------------------------------------------------------------------------
// tga_queue
// Short first-in first-out queue of classified bytes between the front
// and back parts.
// ----------------------------------------------------------------------------
module tga_queue #(
    parameter int Depth = tga_pkg::QUEUE_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  tga_pkg::tga_item_t push_item,
    output logic               full,
    input  logic               pop,
    output tga_pkg::tga_item_t pop_item,
    output logic               empty
);

    localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CW = $clog2(Depth + 1);

    tga_pkg::tga_item_t entries [Depth];

    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign full     = (count_reg == CW'(Depth));
    assign empty    = (count_reg == '0);
    assign pop_item = entries[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= push_item;
        end
    end

endmodule

/* sv/tga_back.sv */
// ----------------------------------------------------------------------------
// tga_back
// Takes classified bytes from the queue, captures header fields, decodes
// raw and RLE pixel data and drives the registered result port.
// ----------------------------------------------------------------------------
module tga_back (
    input  logic               clk,
    input  logic               rst_n,
    input  tga_pkg::tga_item_t item,
    input  logic               empty,
    output logic               pop,
    output logic               result_valid,
    input  logic               result_ready,
    output tga_pkg::tga_out_t  result_data
);

    tga_pkg::tga_phase_t phase_reg, phase_next;
    logic [15:0] type_reg, type_next;
    logic [15:0] width_reg, width_next;
    logic [15:0] height_reg, height_next;
    logic [7:0]  depth_reg, depth_next;
    logic [31:0] pixels_left_reg, pixels_left_next;
    logic        pkt_run_reg, pkt_run_next;
    logic [7:0]  pkt_left_reg, pkt_left_next;
    logic [1:0]  bip_reg, bip_next;
    logic [31:0] acc_reg, acc_next;
    logic        out_valid_reg, out_valid_next;
    tga_pkg::tga_out_t out_data_reg, out_data_next;

    logic        take;
    logic [2:0]  bpp;
    logic        depth_bad;
    logic [31:0] acc_merged;
    logic        pixel_done;
    logic [7:0]  run_cnt;
    logic [7:0]  cnt_sel;
    logic [31:0] pixels_after;
    logic [7:0]  pkt_left_after;
    tga_pkg::tga_phase_t hdr_phase;
    logic        hdr_end;
    logic        pixel_phase;
    logic        emit;
    tga_pkg::tga_out_t res;

    // Consume a byte whenever the result register can take what it gives
    assign take = !empty && (!out_valid_reg || result_ready);
    assign pop  = take;

    // Shared datapath terms
    always_comb
    begin
        bpp        = depth_reg[5:3];
        depth_bad  = (depth_reg[7:3] == 5'd0) || (depth_reg[7:3] > tga_pkg::MAX_BPP);
        acc_merged = acc_reg | ({24'd0, item.data_byte} << {bip_reg, 3'b000});
        pixel_done = (({1'b0, bip_reg} + 3'd1) >= bpp);
        // run packets are clamped to the pixels still owed
        run_cnt    = (pixels_left_reg < {24'd0, pkt_left_reg})
                     ? pixels_left_reg[7:0] : pkt_left_reg;
        cnt_sel    = (phase_reg == tga_pkg::PH_PACKET_PIXEL && pkt_run_reg) ? run_cnt : 8'd1;
        pixels_after   = pixels_left_reg - {24'd0, cnt_sel};
        pkt_left_after = pkt_run_reg ? 8'd0 : pkt_left_reg - 8'd1;

        // phase entered at the end of the header
        if (type_reg == tga_pkg::TYPE_RAW_COLOUR || type_reg == tga_pkg::TYPE_RAW_GREY)
        begin
            hdr_phase = tga_pkg::PH_RAW_PIXEL;
        end
        else if (type_reg[tga_pkg::TYPE_RLE_BIT])
        begin
            hdr_phase = tga_pkg::PH_PACKET_HEAD;
        end
        else
        begin
            hdr_phase = tga_pkg::PH_DONE;
        end
        if (pixels_left_reg == 32'd0)
        begin
            hdr_phase = tga_pkg::PH_DONE;
        end

        hdr_end     = item.is_header && (item.hdr_pos == tga_pkg::HDR_LAST);
        pixel_phase = (phase_reg == tga_pkg::PH_RAW_PIXEL)
                      || (phase_reg == tga_pkg::PH_PACKET_PIXEL);
    end

    // Next state
    always_comb
    begin
        phase_next       = phase_reg;
        type_next        = type_reg;
        width_next       = width_reg;
        height_next      = height_reg;
        depth_next       = depth_reg;
        pixels_left_next = pixels_left_reg;
        pkt_run_next     = pkt_run_reg;
        pkt_left_next    = pkt_left_reg;
        bip_next         = bip_reg;
        acc_next         = acc_reg;
        if (take)
        begin
            if (item.is_header)
            begin
                case (item.hdr_pos)
                    tga_pkg::HDR_TYPE_LO:   type_next[7:0]    = item.data_byte;
                    tga_pkg::HDR_TYPE_HI:   type_next[15:8]   = item.data_byte;
                    tga_pkg::HDR_WIDTH_LO:  width_next[7:0]   = item.data_byte;
                    tga_pkg::HDR_WIDTH_HI:  width_next[15:8]  = item.data_byte;
                    tga_pkg::HDR_HEIGHT_LO: height_next[7:0]  = item.data_byte;
                    tga_pkg::HDR_HEIGHT_HI: height_next[15:8] = item.data_byte;
                    tga_pkg::HDR_DEPTH:
                    begin
                        depth_next       = item.data_byte;
                        // pixel total ready one byte ahead of the header end
                        pixels_left_next = {16'd0, width_reg} * {16'd0, height_reg};
                    end
                    tga_pkg::HDR_LAST:
                    begin
                        bip_next   = 2'd0;
                        acc_next   = 32'd0;
                        phase_next = depth_bad ? tga_pkg::PH_DONE : hdr_phase;
                    end
                    default: ;
                endcase
            end
            else
            begin
                case (phase_reg)
                    tga_pkg::PH_RAW_PIXEL:
                    begin
                        bip_next = pixel_done ? 2'd0 : bip_reg + 2'd1;
                        acc_next = pixel_done ? 32'd0 : acc_merged;
                        if (pixel_done)
                        begin
                            pixels_left_next = pixels_after;
                            if (pixels_after == 32'd0)
                            begin
                                phase_next = tga_pkg::PH_DONE;
                            end
                        end
                    end
                    tga_pkg::PH_PACKET_HEAD:
                    begin
                        pkt_run_next  = item.data_byte[7];
                        pkt_left_next = {1'b0, item.data_byte[6:0]} + 8'd1;
                        bip_next      = 2'd0;
                        acc_next      = 32'd0;
                        phase_next    = tga_pkg::PH_PACKET_PIXEL;
                    end
                    tga_pkg::PH_PACKET_PIXEL:
                    begin
                        bip_next = pixel_done ? 2'd0 : bip_reg + 2'd1;
                        acc_next = pixel_done ? 32'd0 : acc_merged;
                        if (pixel_done)
                        begin
                            pixels_left_next = pixels_after;
                            pkt_left_next    = pkt_left_after;
                            if (pixels_after == 32'd0)
                            begin
                                phase_next = tga_pkg::PH_DONE;
                            end
                            else if (pkt_left_after == 8'd0)
                            begin
                                phase_next = tga_pkg::PH_PACKET_HEAD;
                            end
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // Result generation
    always_comb
    begin
        emit = 1'b0;
        res.kind         = tga_pkg::KIND_HEADER;
        res.pixel_value  = 32'd0;
        res.repeat_count = 8'd0;
        res.image_width  = width_reg;
        res.image_height = height_reg;
        res.bit_depth    = depth_reg;
        res.last         = 1'b0;
        if (take)
        begin
            if (hdr_end)
            begin
                emit = 1'b1;
                if (depth_bad)
                begin
                    res.kind = tga_pkg::KIND_BAD_DEPTH;
                    res.last = 1'b1;
                end
                else
                begin
                    res.last = (hdr_phase == tga_pkg::PH_DONE);
                end
            end
            else if (!item.is_header && pixel_phase && pixel_done)
            begin
                emit             = 1'b1;
                res.kind         = tga_pkg::KIND_RUN;
                res.pixel_value  = acc_merged;
                res.repeat_count = cnt_sel;
                res.last         = (pixels_after == 32'd0);
            end
        end
        out_valid_next = emit ? 1'b1 : (result_ready ? 1'b0 : out_valid_reg);
        out_data_next  = emit ? res : out_data_reg;
    end

    assign result_valid = out_valid_reg;
    assign result_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= tga_pkg::PH_DONE;
            type_reg        <= 16'd0;
            width_reg       <= 16'd0;
            height_reg      <= 16'd0;
            depth_reg       <= 8'd0;
            pixels_left_reg <= 32'd0;
            pkt_run_reg     <= 1'b0;
            pkt_left_reg    <= 8'd0;
            bip_reg         <= 2'd0;
            acc_reg         <= 32'd0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            phase_reg       <= phase_next;
            type_reg        <= type_next;
            width_reg       <= width_next;
            height_reg      <= height_next;
            depth_reg       <= depth_next;
            pixels_left_reg <= pixels_left_next;
            pkt_run_reg     <= pkt_run_next;
            pkt_left_reg    <= pkt_left_next;
            bip_reg         <= bip_next;
            acc_reg         <= acc_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

endmodule

/* sv/tga_image_stream_decoder.sv */
// ----------------------------------------------------------------------------
// tga_image_stream_decoder
// TGA file decoder: header report, raw and RLE pixel runs.
// ----------------------------------------------------------------------------
// Takes one file byte per beat and sustains one byte per cycle for as long
// as results are taken. A front stage tags each byte as header (with its
// position) or body and writes it into a QueueDepth-entry queue; the back
// stage reads one byte per cycle while any are queued, parses it and loads
// at most one result into the output register. A stall on the result port
// holds the back stage only; the front keeps taking bytes until the queue
// is full. The width-by-height pixel total is formed by a single 16x16
// multiplier on the bit-depth byte.
module tga_image_stream_decoder #(
    parameter int QueueDepth = tga_pkg::QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              byte_valid,
    output logic              byte_ready,
    input  tga_pkg::tga_in_t  byte_data,
    output logic              result_valid,
    input  logic              result_ready,
    output tga_pkg::tga_out_t result_data
);

    logic               queue_full;
    logic               queue_empty;
    logic               push;
    logic               pop;
    tga_pkg::tga_item_t push_item;
    tga_pkg::tga_item_t pop_item;

    // Byte classification
    tga_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .byte_data  (byte_data),
        .queue_full (queue_full),
        .push       (push),
        .push_item  (push_item)
    );

    // Decoupling queue
    tga_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (queue_full),
        .pop       (pop),
        .pop_item  (pop_item),
        .empty     (queue_empty)
    );

    // Parsing and decoding
    tga_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (pop_item),
        .empty        (queue_empty),
        .pop          (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_data  (result_data)
    );

endmodule

/* test/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the TGA image stream decoder.
// ----------------------------------------------------------------------------
// File bytes go in as input beats with random gaps. The result port is
// stalled at random. Each accepted input beat is decoded by a bit-accurate
// model of the parser held in a scoreboard. The model queues the header
// report or pixel run that the beat should cause. Every result beat is
// compared field by field with the oldest queued one.
// Stimulus starts with a few hand-built files. Random images follow: raw,
// RLE, unsupported types and bit depths, and empty images. Some files are
// cut short to restart mid-image, some have trailing bytes, and some
// stretches are pure noise.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IMAGE_BYTES  = 550;
    localparam int CYCLE_LIMIT  = 600_000;
    localparam int DRAIN_CYCLES = 16;
    localparam int BODY_BUDGET  = 48;

    // Parser position, header phase included
    typedef enum logic [2:0] {
        ST_HEADER,
        ST_RAW_PIXEL,
        ST_PACKET_HEAD,
        ST_PACKET_PIXEL,
        ST_DONE
    } parse_state_t;

    // ------------------------------------------------------------------------
    // Decoder model and result scoreboard
    // ------------------------------------------------------------------------
    class tga_scoreboard;
        parse_state_t      state       = ST_HEADER;
        logic [4:0]        hdr_pos     = '0;
        logic [15:0]       img_type    = '0;
        logic [15:0]       img_width   = '0;
        logic [15:0]       img_height  = '0;
        logic [7:0]        img_depth   = '0;
        logic [31:0]       pixels_left = '0;
        bit                packet_run  = 1'b0;
        logic [7:0]        packet_left = '0;
        logic [1:0]        pixel_byte  = '0;
        logic [31:0]       pixel_acc   = '0;
        tga_pkg::tga_out_t awaited_results[$];
        int                faults      = 0;

        function void restart();
            state       = ST_HEADER;
            hdr_pos     = '0;
            img_type    = '0;
            img_width   = '0;
            img_height  = '0;
            img_depth   = '0;
            pixels_left = '0;
            packet_run  = 1'b0;
            packet_left = '0;
            pixel_byte  = '0;
            pixel_acc   = '0;
        endfunction

        function void add_result(logic [1:0] kind, logic [31:0] pix, logic [7:0] cnt,
                                 bit last);
            tga_pkg::tga_out_t r;
            r.kind         = kind;
            r.pixel_value  = pix;
            r.repeat_count = cnt;
            r.image_width  = img_width;
            r.image_height = img_height;
            r.bit_depth    = img_depth;
            r.last         = last;
            awaited_results.push_back(r);
        endfunction

        // Little-endian pixel assembly; high when the pixel is complete
        function bit gather_pixel_byte(logic [7:0] b);
            int bpp;
            bpp = int'(img_depth) / 8;
            pixel_acc |= 32'(b) << (8 * pixel_byte);
            if (int'(pixel_byte) + 1 >= bpp)
            begin
                pixel_byte = '0;
                return 1'b1;
            end
            pixel_byte++;
            return 1'b0;
        endfunction

        // Advance the parser by one accepted input beat
        function void decode_byte(tga_pkg::tga_in_t beat);
            logic [7:0]  b;
            int          bpp;
            logic [31:0] pix;
            logic [31:0] cnt;
            b = beat.data_byte;
            if (beat.start_of_file)
                restart();
            case (state)
                ST_HEADER:
                begin
                    case (hdr_pos)
                        tga_pkg::HDR_TYPE_LO:   img_type[7:0]    = b;
                        tga_pkg::HDR_TYPE_HI:   img_type[15:8]   = b;
                        tga_pkg::HDR_WIDTH_LO:  img_width[7:0]   = b;
                        tga_pkg::HDR_WIDTH_HI:  img_width[15:8]  = b;
                        tga_pkg::HDR_HEIGHT_LO: img_height[7:0]  = b;
                        tga_pkg::HDR_HEIGHT_HI: img_height[15:8] = b;
                        tga_pkg::HDR_DEPTH:     img_depth        = b;
                        default: ;
                    endcase
                    if (hdr_pos < tga_pkg::HDR_LAST)
                    begin
                        hdr_pos++;
                        return;
                    end
                    hdr_pos = '0;
                    bpp = int'(img_depth) / 8;
                    if (bpp == 0 || bpp > int'(tga_pkg::MAX_BPP))
                    begin
                        state = ST_DONE;
                        add_result(tga_pkg::KIND_BAD_DEPTH, '0, '0, 1'b1);
                        return;
                    end
                    pixels_left = 32'(img_width) * 32'(img_height);
                    pixel_byte  = '0;
                    pixel_acc   = '0;
                    if (img_type == tga_pkg::TYPE_RAW_COLOUR ||
                        img_type == tga_pkg::TYPE_RAW_GREY)
                        state = ST_RAW_PIXEL;
                    else if (img_type[tga_pkg::TYPE_RLE_BIT])
                        state = ST_PACKET_HEAD;
                    else
                        state = ST_DONE;
                    if (pixels_left == 0)
                        state = ST_DONE;
                    add_result(tga_pkg::KIND_HEADER, '0, '0, state == ST_DONE);
                end
                ST_RAW_PIXEL:
                begin
                    if (!gather_pixel_byte(b))
                        return;
                    pix       = pixel_acc;
                    pixel_acc = '0;
                    pixels_left--;
                    if (pixels_left == 0)
                        state = ST_DONE;
                    add_result(tga_pkg::KIND_RUN, pix, 8'd1, state == ST_DONE);
                end
                ST_PACKET_HEAD:
                begin
                    packet_run  = b[7];
                    packet_left = {1'b0, b[6:0]} + 8'd1;
                    pixel_byte  = '0;
                    pixel_acc   = '0;
                    state       = ST_PACKET_PIXEL;
                end
                ST_PACKET_PIXEL:
                begin
                    if (!gather_pixel_byte(b))
                        return;
                    pix       = pixel_acc;
                    pixel_acc = '0;
                    // runs are clamped to what is left of the image
                    if (packet_run)
                    begin
                        cnt = 32'(packet_left);
                        if (cnt > pixels_left)
                            cnt = pixels_left;
                        packet_left = '0;
                    end
                    else
                    begin
                        cnt = 32'd1;
                        packet_left--;
                    end
                    pixels_left -= cnt;
                    if (pixels_left == 0)
                        state = ST_DONE;
                    else if (packet_left == 0)
                        state = ST_PACKET_HEAD;
                    add_result(tga_pkg::KIND_RUN, pix, cnt[7:0], state == ST_DONE);
                end
                default: ;
            endcase
        endfunction

        function string show(tga_pkg::tga_out_t r);
            return $sformatf("kind %0d pixel %h count %0d size %0dx%0d depth %0d last %0b",
                             r.kind, r.pixel_value, r.repeat_count, r.image_width,
                             r.image_height, r.bit_depth, r.last);
        endfunction

        function void log_fault(string msg);
            faults++;
            if (faults <= 10)
                $display("%s", msg);
        endfunction

        function void check_result(tga_pkg::tga_out_t got);
            tga_pkg::tga_out_t want;
            if (awaited_results.size() == 0)
            begin
                log_fault({"unexpected result beat: ", show(got)});
                return;
            end
            want = awaited_results.pop_front();
            if (got.kind !== want.kind || got.pixel_value !== want.pixel_value ||
                got.repeat_count !== want.repeat_count ||
                got.image_width !== want.image_width ||
                got.image_height !== want.image_height ||
                got.bit_depth !== want.bit_depth || got.last !== want.last)
                log_fault({"result mismatch\n  expected ", show(want),
                           "\n  actual   ", show(got)});
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n;
    logic              byte_valid;
    logic              byte_ready;
    tga_pkg::tga_in_t  byte_data;
    logic              result_valid;
    logic              result_ready;
    tga_pkg::tga_out_t result_data;

    tga_scoreboard sb;
    logic [7:0]    file_bytes[$];
    int            items_sent    = 0;
    bit            sender_steady = 1'b0;
    int unsigned   cycle_count   = 0;

    tga_image_stream_decoder dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_ready   (byte_ready),
        .byte_data    (byte_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_data  (result_data)
    );

    // 50 MHz clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("[tga_image_stream_decoder] ERROR");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Result port stalls, with stretches of steady ready
    initial
    begin
        forever
        begin
            if ($urandom_range(0, 9) < 2)
            begin
                result_ready <= 1'b1;
                repeat ($urandom_range(40, 160)) @(posedge clk);
            end
            else
            begin
                result_ready <= 1'b0;
                repeat (pick_gap() + 1) @(posedge clk);
                result_ready <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
    end

    // Result monitor
    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
            sb.check_result(result_data);
    end

    // One input beat; entered and left at a rising edge
    task automatic send_byte(input logic [7:0] b, input bit sof);
        tga_pkg::tga_in_t beat;
        int               gap;
        gap = sender_steady ? 0 : pick_gap();
        beat.data_byte     = b;
        beat.start_of_file = sof;
        if (gap > 0)
        begin
            byte_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_valid <= 1'b1;
        byte_data  <= beat;
        do
            @(posedge clk);
        while (!byte_ready);
        sb.decode_byte(beat);
    endtask

    task automatic send_file(input bit flagged, input int counted);
        for (int i = 0; i < file_bytes.size(); i++)
            send_byte(file_bytes[i], flagged && (i == 0));
        items_sent += counted;
        file_bytes.delete();
    endtask

    // 18-byte header; fields the decoder skips are random
    task automatic push_header(input logic [15:0] img_type, input logic [15:0] w,
                               input logic [15:0] h, input logic [7:0] depth);
        for (int i = 0; i < 18; i++)
        begin
            case (5'(i))
                tga_pkg::HDR_TYPE_LO:   file_bytes.push_back(img_type[7:0]);
                tga_pkg::HDR_TYPE_HI:   file_bytes.push_back(img_type[15:8]);
                tga_pkg::HDR_WIDTH_LO:  file_bytes.push_back(w[7:0]);
                tga_pkg::HDR_WIDTH_HI:  file_bytes.push_back(w[15:8]);
                tga_pkg::HDR_HEIGHT_LO: file_bytes.push_back(h[7:0]);
                tga_pkg::HDR_HEIGHT_HI: file_bytes.push_back(h[15:8]);
                tga_pkg::HDR_DEPTH:     file_bytes.push_back(depth);
                default:                file_bytes.push_back(8'($urandom));
            endcase
        end
    endtask

    task automatic push_pixel(input int bpp, inout int budget);
        for (int k = 0; k < bpp; k++)
            file_bytes.push_back(8'($urandom));
        budget -= bpp;
    endtask

    // Random image: header and a body that is usually well formed
    task automatic send_random_image();
        logic [15:0] img_type;
        logic [15:0] w;
        logic [15:0] h;
        logic [7:0]  depth;
        int          r;
        int          bpp;
        int          budget;
        int          cnt;
        int          hi;
        int          counted;
        bit          run;
        longint      left;

        r = $urandom_range(0, 9);
        case (r)
            0, 1:    img_type = tga_pkg::TYPE_RAW_COLOUR;
            2:       img_type = tga_pkg::TYPE_RAW_GREY;
            3, 4:    img_type = 16'd10;
            5:       img_type = ($urandom_range(0, 1) != 0) ? 16'd9 : 16'd11;
            6:       img_type = 16'($urandom) | 16'h0008;
            7:       img_type = 16'($urandom);
            8:       img_type = 16'($urandom) & ~16'h0008;
            default: img_type = 16'd1;
        endcase

        r = $urandom_range(0, 9);
        if (r < 8)
            depth = 8'(8 * $urandom_range(1, 4));
        else
            depth = 8'($urandom);

        r = $urandom_range(0, 19);
        if (r < 14)
        begin
            w = 16'($urandom_range(0, 4));
            h = 16'($urandom_range(0, 4));
        end
        else if (r < 18)
        begin
            w = 16'($urandom_range(1, 12));
            h = 16'($urandom_range(1, 3));
        end
        else if (r == 18)
        begin
            w = 16'hFFFF;
            h = 16'($urandom_range(1, 65535));
        end
        else
        begin
            w = 16'($urandom);
            h = 16'($urandom);
        end

        push_header(img_type, w, h, depth);
        bpp    = int'(depth) / 8;
        left   = longint'(w) * longint'(h);
        budget = BODY_BUDGET;

        // body only where the header leads into pixels
        if (bpp >= 1 && bpp <= int'(tga_pkg::MAX_BPP) && left != 0)
        begin
            if (img_type == tga_pkg::TYPE_RAW_COLOUR || img_type == tga_pkg::TYPE_RAW_GREY)
            begin
                while (left > 0 && budget > 0)
                begin
                    push_pixel(bpp, budget);
                    left--;
                end
            end
            else if (img_type[tga_pkg::TYPE_RLE_BIT])
            begin
                while (left > 0 && budget > 0)
                begin
                    run = ($urandom_range(0, 1) != 0);
                    hi  = (left + 3 > 128) ? 128 : int'(left) + 3;
                    r   = $urandom_range(0, 9);
                    if (r < 7)
                        cnt = $urandom_range(1, 4);
                    else if (r < 9)
                        cnt = $urandom_range(1, hi);
                    else
                        cnt = 128;
                    file_bytes.push_back({run, 7'(cnt - 1)});
                    budget--;
                    if (run)
                        push_pixel(bpp, budget);
                    else
                        for (int k = 0; k < cnt && budget > 0; k++)
                            push_pixel(bpp, budget);
                    left -= (longint'(cnt) > left) ? left : longint'(cnt);
                end
            end
        end
        counted = file_bytes.size();

        // cut short for a restart mid-image, or add bytes past the end
        r = $urandom_range(0, 99);
        if (r < 8)
        begin
            counted = $urandom_range(1, file_bytes.size());
            while (file_bytes.size() > counted)
                void'(file_bytes.pop_back());
        end
        else if (r < 28)
        begin
            repeat ($urandom_range(1, 4)) file_bytes.push_back(8'($urandom));
        end
        send_file(1'b1, counted);
    endtask

    // Noise with the odd stray start flag
    task automatic send_noise();
        repeat ($urandom_range(1, 20))
            send_byte(8'($urandom), $urandom_range(0, 7) == 0);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        sb = new;
        rst_n      <= 1'b0;
        byte_valid <= 1'b0;
        byte_data  <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // first image without a start flag: raw packet of two, run of six
        // clamped to the last pixel, then bytes past the end
        push_header(16'd10, 16'd3, 16'd1, 8'd8);
        file_bytes.push_back(8'h01);
        file_bytes.push_back(8'h00);
        file_bytes.push_back(8'hFF);
        file_bytes.push_back(8'h85);
        file_bytes.push_back(8'h5A);
        file_bytes.push_back(8'hC3);
        file_bytes.push_back(8'h3C);
        send_file(1'b0, 23);

        // 32-bit raw image abandoned halfway through its second pixel
        push_header(tga_pkg::TYPE_RAW_COLOUR, 16'd2, 16'd1, 8'd32);
        repeat (4) file_bytes.push_back(8'hFF);
        file_bytes.push_back(8'h00);
        file_bytes.push_back(8'h00);
        send_file(1'b1, 24);

        // all-ones header: depth far too large
        push_header(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
        send_file(1'b1, 18);

        // empty image: zero width and height, grey with a depth of 8
        push_header(tga_pkg::TYPE_RAW_GREY, 16'd0, 16'd0, 8'd8);
        send_file(1'b1, 18);

        while (items_sent < IMAGE_BYTES)
        begin
            sender_steady = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 19) == 0)
                send_noise();
            else
                send_random_image();
        end
        byte_valid <= 1'b0;

        while (sb.awaited_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.faults == 0)
            $display("[tga_image_stream_decoder] OK");
        else
            $display("[tga_image_stream_decoder] ERROR");
        $finish;
    end

endmodule
